### design/mtf_pkg.sv
// ============================================================================
// Mutex table package
// Shared constants, operation and status codes, and free-list types.
// ============================================================================
`default_nettype none

package mtf_pkg;

  // Number of mutexes in the table.
  localparam int MUTEX_COUNT = 64;
  // Bits needed to name one table entry.
  localparam int IDX_W = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;

  // Width of the ports that carry a mutex id.
  localparam int ID_W = 10;
  localparam int THREAD_W = 32;
  localparam int ENV_W = 32;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_LOCK    = 2'd2,
    OP_UNLOCK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MUTEX = 3'd1,
    ST_BAD_ENV   = 3'd2,
    ST_NO_FREE   = 3'd3,
    ST_LOCKED    = 3'd4
  } status_t;

  // A free-list link: an entry number and a flag that marks it as not null.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } link_t;

  // Update of the free list for one request.
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_idx;
  } fl_cmd_t;

endpackage

`default_nettype wire

### design/mtf_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module mtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/mtf_free_list.sv
// ============================================================================
// Mutex free list
// Head register and link memory of the singly linked list of free entries.
// ============================================================================
`default_nettype none

module mtf_free_list
  import mtf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    accept,
  input  wire fl_cmd_t cmd,
  output link_t        head
);

  link_t             head_next;
  link_t             link_rd;
  link_t             head_link;
  link_t             reset_link;
  logic [MUTEX_COUNT-1:0] written;
  logic              byp_valid;
  logic [IDX_W-1:0]  byp_addr;
  link_t             byp_data;

  // The link memory is read at the head that the next request will see.
  mtf_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (MUTEX_COUNT)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (cmd.push_idx),
    .wr_data (head),
    .rd_en   (accept),
    .rd_addr (head_next.idx),
    .rd_data (link_rd)
  );

  // An entry whose link was never written still points to the entry after it.
  always_comb begin
    reset_link.valid = (32'(head.idx) + 32'd1) < 32'(MUTEX_COUNT);
    reset_link.idx   = head.idx + IDX_W'(1);
  end

  // A write made in the same edge as the read is taken from the bypass copy.
  always_comb begin
    if (byp_valid && (byp_addr == head.idx)) begin
      head_link = byp_data;
    end else if (written[head.idx]) begin
      head_link = link_rd;
    end else begin
      head_link = reset_link;
    end
  end

  // Pop and push never come together.
  always_comb begin
    head_next = head;
    if (cmd.pop) begin
      head_next = head_link;
    end else if (cmd.push) begin
      head_next.valid = 1'b1;
      head_next.idx   = cmd.push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b1;
      head.idx   <= '0;
      written    <= '0;
      byp_valid  <= 1'b0;
    end else begin
      head <= head_next;
      if (cmd.pop || cmd.push) begin
        byp_valid <= cmd.push;
      end
      if (cmd.push) begin
        written[cmd.push_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      byp_addr <= cmd.push_idx;
      byp_data <= head;
    end
  end

endmodule

`default_nettype wire

### design/mutex_table_with_free_list.sv
// ============================================================================
// Mutex table with free list
// Create, destroy, lock and unlock requests on a fixed table of mutexes.
// ============================================================================
// Each request passes through the input register and then the result register.
// One request per cycle while the result side is not stalled; each request gives exactly one result.
// The input and result registers each hold one request, so the input side
// stalls only in reset or while the result register is full and stalled.
// Reset clears all flags and rebuilds the free list at once; no clearing pass.
`default_nettype none

module mutex_table_with_free_list
  import mtf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          operation,
  input  wire logic [ID_W-1:0]     mutex_index,
  input  wire logic [THREAD_W-1:0] thread_id,
  input  wire logic [ENV_W-1:0]    env_id,
  input  wire logic                env_valid,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               status,
  output logic [ID_W-1:0]          created_id
);

  // Request register. The owner-thread memory is read at the same edge, so
  // its data lines up with the registered request in the next cycle.
  logic                s1_valid;
  op_t                 s1_op;
  logic [ID_W-1:0]     s1_index;
  logic [THREAD_W-1:0] s1_thread;
  logic [ENV_W-1:0]    s1_env;
  logic                s1_env_valid;

  logic accept;
  logic fire;

  // Per-entry flags live in flip-flops so that reset clears them at once.
  logic [MUTEX_COUNT-1:0] reserved;
  logic [MUTEX_COUNT-1:0] locked;

  link_t   head;
  fl_cmd_t fl_cmd;

  logic [IDX_W-1:0]    entry;
  logic [IDX_W-1:0]    target;
  logic                in_range;
  logic [THREAD_W-1:0] owner_rd;
  logic [THREAD_W-1:0] owner;
  logic                owner_byp_valid;
  logic [IDX_W-1:0]    owner_byp_addr;
  logic [THREAD_W-1:0] owner_byp_data;

  status_t         st;
  logic [ID_W-1:0] created;
  logic            owner_we;
  logic            env_we;
  logic            res_we;
  logic            res_val;
  logic            lock_we;
  logic            lock_val;

  // The request in the input register completes when the result register is
  // empty or its result is taken in the same cycle.
  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = rst || (s1_valid && !fire);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op        <= op_t'(operation);
      s1_index     <= mutex_index;
      s1_thread    <= thread_id;
      s1_env       <= env_id;
      s1_env_valid <= env_valid;
    end
  end

  // Owner thread of each mutex. Its value is used only while the entry is locked,
  // and a lock always writes it first, so no reset value is needed.
  mtf_ram #(
    .WIDTH (THREAD_W),
    .DEPTH (MUTEX_COUNT)
  ) u_owner_thread_ram (
    .clk     (clk),
    .wr_en   (owner_we),
    .wr_addr (entry),
    .wr_data (s1_thread),
    .rd_en   (accept),
    .rd_addr (mutex_index[IDX_W-1:0]),
    .rd_data (owner_rd)
  );

  // Owning environment, recorded on create. Nothing in the block reads it back.
  mtf_ram #(
    .WIDTH (ENV_W),
    .DEPTH (MUTEX_COUNT)
  ) u_owner_env_ram (
    .clk     (clk),
    .wr_en   (env_we),
    .wr_addr (head.idx),
    .wr_data (s1_env),
    .rd_en   (1'b0),
    .rd_addr (head.idx),
    .rd_data ()
  );

  mtf_free_list u_free_list (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (fl_cmd),
    .head   (head)
  );

  // The owner memory was read at the edge where the previous request may have
  // written the same entry; that write is taken from the bypass copy instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_byp_valid <= 1'b0;
    end else if (fire) begin
      owner_byp_valid <= owner_we;
    end
  end

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_byp_addr <= entry;
      owner_byp_data <= s1_thread;
    end
  end

  assign entry    = s1_index[IDX_W-1:0];
  assign in_range = 32'(s1_index) < 32'(MUTEX_COUNT);
  assign owner    = (owner_byp_valid && (owner_byp_addr == entry)) ? owner_byp_data
                                                                   : owner_rd;
  // Create works on the free-list head, every other request on its own id.
  assign target   = (s1_op == OP_CREATE) ? head.idx : entry;

  // Decision for the request in the input register. Every state change is
  // qualified by fire, so a stalled request changes nothing.
  always_comb begin
    st              = ST_OK;
    created         = '0;
    owner_we        = 1'b0;
    env_we          = 1'b0;
    res_we          = 1'b0;
    res_val         = 1'b0;
    lock_we         = 1'b0;
    lock_val        = 1'b0;
    fl_cmd.pop      = 1'b0;
    fl_cmd.push     = 1'b0;
    fl_cmd.push_idx = entry;
    if (s1_op == OP_CREATE) begin
      if (!s1_env_valid) begin
        st = ST_BAD_ENV;
      end else if (!head.valid) begin
        st = ST_NO_FREE;
      end else begin
        // Take the head entry: reserved, unlocked, owned by this environment.
        created    = ID_W'(head.idx);
        fl_cmd.pop = fire;
        env_we     = fire;
        res_we     = fire;
        res_val    = 1'b1;
        lock_we    = fire;
        lock_val   = 1'b0;
      end
    end else if (!in_range || !reserved[entry]) begin
      st = ST_BAD_MUTEX;
    end else begin
      unique case (s1_op)
        OP_DESTROY: begin
          // The locked flag is left alone; the create that reuses the entry clears it.
          res_we      = fire;
          res_val     = 1'b0;
          fl_cmd.push = fire;
        end
        OP_LOCK: begin
          if (locked[entry]) begin
            // A relock by the holding thread succeeds and changes nothing.
            if (owner != s1_thread) begin
              st = ST_LOCKED;
            end
          end else begin
            lock_we  = fire;
            lock_val = 1'b1;
            owner_we = fire;
          end
        end
        OP_UNLOCK: begin
          // No owner check on unlock.
          lock_we  = fire;
          lock_val = 1'b0;
        end
        default: begin
          st = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
      locked   <= '0;
    end else begin
      if (res_we) begin
        reserved[target] <= res_val;
      end
      if (lock_we) begin
        locked[target] <= lock_val;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status     <= st;
      created_id <= created;
    end
  end

endmodule

`default_nettype wire

### sim/mtf_checker.sv
// ============================================================================
// Mutex table checker
// Watches both channels of the mutex table, predicts the result of every
// accepted request and compares each accepted result with the oldest one.
// ============================================================================
`timescale 1ns / 1ps

module mtf_checker
  import mtf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire logic [1:0]          operation,
  input  wire logic [ID_W-1:0]     mutex_index,
  input  wire logic [THREAD_W-1:0] thread_id,
  input  wire logic [ENV_W-1:0]    env_id,
  input  wire logic                env_valid,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire logic [2:0]          status,
  input  wire logic [ID_W-1:0]     created_id,
  output int                       fail_count,
  output int                       outstanding
);

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] created_id;
  } mutex_result_t;

  // Shadow copy of the mutex table.
  logic                is_reserved [MUTEX_COUNT];
  logic                is_locked   [MUTEX_COUNT];
  logic [THREAD_W-1:0] holder      [MUTEX_COUNT];
  logic [ENV_W-1:0]    owner_env   [MUTEX_COUNT];
  link_t               free_next   [MUTEX_COUNT];
  link_t               free_head;

  mutex_result_t       expected_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count = fail_count + 1;
  endtask

  function automatic void rebuild_table();
    for (int i = 0; i < MUTEX_COUNT; i++) begin
      is_reserved[i]     = 1'b0;
      is_locked[i]       = 1'b0;
      holder[i]          = '0;
      owner_env[i]       = '0;
      free_next[i].valid = (i + 1 < MUTEX_COUNT);
      free_next[i].idx   = (i + 1 < MUTEX_COUNT) ? IDX_W'(i + 1) : '0;
    end
    free_head = '{valid: 1'b1, idx: '0};
  endfunction

  // Applies one request to the shadow table and returns what the block owes.
  function automatic mutex_result_t apply_request(input op_t op,
                                                  input logic [ID_W-1:0] idx,
                                                  input logic [THREAD_W-1:0] thr,
                                                  input logic [ENV_W-1:0] env,
                                                  input logic env_ok);
    mutex_result_t    r;
    logic [IDX_W-1:0] e;
    r.status     = ST_OK;
    r.created_id = '0;
    e            = idx[IDX_W-1:0];
    if (op == OP_CREATE) begin
      if (!env_ok) begin
        r.status = ST_BAD_ENV;
      end else if (!free_head.valid) begin
        r.status = ST_NO_FREE;
      end else begin
        e              = free_head.idx;
        free_head      = free_next[e];
        is_reserved[e] = 1'b1;
        is_locked[e]   = 1'b0;
        owner_env[e]   = env;
        r.created_id   = ID_W'(e);
      end
    end else if (idx >= MUTEX_COUNT || !is_reserved[e]) begin
      r.status = ST_BAD_MUTEX;
    end else begin
      case (op)
        OP_DESTROY: begin
          is_reserved[e] = 1'b0;
          free_next[e]   = free_head;
          free_head      = '{valid: 1'b1, idx: e};
        end
        OP_LOCK: begin
          if (is_locked[e]) begin
            if (holder[e] != thr) r.status = ST_LOCKED;
          end else begin
            is_locked[e] = 1'b1;
            holder[e]    = thr;
          end
        end
        default: begin
          is_locked[e] = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    mutex_result_t want;
    if (rst) begin
      rebuild_table();
      expected_results.delete();
      outstanding = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_request(op_t'(operation), mutex_index,
                                                 thread_id, env_id, env_valid));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result (status %0d) with no request waiting",
                                    status));
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      status, want.status));
          if (created_id !== want.created_id)
            report_mismatch($sformatf("created_id got %0d, expected %0d",
                                      created_id, want.created_id));
        end
      end
      outstanding = expected_results.size();
    end
  end

endmodule

### sim/tb.sv
// ============================================================================
// Mutex table testbench
// Drives create, destroy, lock and unlock requests into the mutex table with
// random idling on both channels; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ============================================================================
`timescale 1ns / 1ps

module tb;
  import mtf_pkg::*;

  // Clock and reset. Every input of the block starts at a known value.
  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic [1:0]          operation   = '0;
  logic [ID_W-1:0]     mutex_index = '0;
  logic [THREAD_W-1:0] thread_id   = '0;
  logic [ENV_W-1:0]    env_id      = '0;
  logic                env_valid   = 1'b0;
  logic                out_stall   = 1'b0;

  logic                in_stall;
  logic                out_valid;
  logic [2:0]          status;
  logic [ID_W-1:0]     created_id;

  int                  fail_count;
  int                  outstanding;

  // When set, the matching side runs flat out with no idle cycles at all.
  logic                send_calm = 1'b0;
  logic                recv_calm = 1'b0;

  // A few thread ids that recur so that relocks and contention actually happen.
  logic [THREAD_W-1:0] thread_pool [4];

  always #2 clk = ~clk;

  mutex_table_with_free_list DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .mutex_index (mutex_index),
    .thread_id   (thread_id),
    .env_id      (env_id),
    .env_valid   (env_valid),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .created_id  (created_id)
  );

  mtf_checker table_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .mutex_index (mutex_index),
    .thread_id   (thread_id),
    .env_id      (env_id),
    .env_valid   (env_valid),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .created_id  (created_id),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Offers one request after a random idle gap and returns just after the
  // rising edge that accepted it. The stall is looked at on the falling edge,
  // where it has settled, so the accept decision never races the block.
  task automatic send_request(input op_t op, input logic [ID_W-1:0] idx,
                              input logic [THREAD_W-1:0] thr,
                              input logic [ENV_W-1:0] env, input logic env_ok);
    int   gap;
    logic taken;
    gap = send_calm ? 0 : $urandom_range(16, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    mutex_index <= idx;
    thread_id   <= thr;
    env_id      <= env;
    env_valid   <= env_ok;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Holds the sender off until every request in flight has its result.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // One random request. The create and destroy shares set how full the table
  // runs; the rest is split between lock and unlock. Ids mostly fall inside
  // the table so that most requests reach a reserved entry.
  task automatic random_request(input int create_pct, input int destroy_pct);
    int                  roll;
    op_t                 op;
    logic [ID_W-1:0]     idx;
    logic [THREAD_W-1:0] thr;
    roll = $urandom_range(99, 0);
    if (roll < create_pct) op = OP_CREATE;
    else if (roll < create_pct + destroy_pct) op = OP_DESTROY;
    else if ($urandom_range(9, 0) < 6) op = OP_LOCK;
    else op = OP_UNLOCK;
    roll = $urandom_range(99, 0);
    if (op == OP_CREATE || roll >= 94) idx = ID_W'($urandom);
    else if (roll < 88) idx = ID_W'($urandom_range(MUTEX_COUNT - 1, 0));
    else idx = ID_W'($urandom_range(2 ** ID_W - 1, MUTEX_COUNT));
    thr = ($urandom_range(99, 0) < 85) ? thread_pool[$urandom_range(3, 0)] : $urandom;
    send_request(op, idx, thr, $urandom, $urandom_range(9, 0) != 0);
  endtask

  // Receiver: before each result it stalls for a random number of cycles,
  // then takes the next result that shows up. Every 64 results it decides
  // afresh whether to stall at all for a while.
  initial begin
    int   hold;
    int   taken_count;
    logic took;
    taken_count = 0;
    forever begin
      hold = recv_calm ? 0 : $urandom_range(16, 0);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk);
        took = (out_valid === 1'b1);
        @(posedge clk);
      end while (!took);
      taken_count++;
      if (taken_count % 64 == 0) recv_calm = ($urandom_range(3, 0) == 0);
    end
  end

  // Stimulus and verdict.
  initial begin
    int create_pct;
    int destroy_pct;
    thread_pool[0] = '0;
    thread_pool[1] = '1;
    thread_pool[2] = $urandom;
    thread_pool[3] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A create without a live environment is refused, and
    // every id-based operation on an entry never created is a bad mutex,
    // both inside and past the end of the table.
    send_request(OP_CREATE,  '0, '0, '0, 1'b0);
    send_request(OP_DESTROY, ID_W'(5), '0, '0, 1'b1);
    send_request(OP_LOCK,    ID_W'(5), '1, '0, 1'b1);
    send_request(OP_UNLOCK,  ID_W'(5), '0, '0, 1'b1);
    send_request(OP_LOCK,    '1, '1, '1, 1'b1);
    send_request(OP_UNLOCK,  ID_W'(MUTEX_COUNT), '0, '0, 1'b1);
    // Two creates take entries 0 and 1 with extreme environment ids.
    send_request(OP_CREATE,  '0, '0, '0, 1'b1);
    send_request(OP_CREATE,  '1, '1, '1, 1'b1);
    // Lock, relock by the same thread, then a lock by another thread.
    send_request(OP_LOCK,    ID_W'(0), '1, '0, 1'b1);
    send_request(OP_LOCK,    ID_W'(0), '1, '0, 1'b1);
    send_request(OP_LOCK,    ID_W'(0), '0, '0, 1'b1);
    // Unlock twice: the second finds the mutex already free.
    send_request(OP_UNLOCK,  ID_W'(0), '1, '0, 1'b1);
    send_request(OP_UNLOCK,  ID_W'(0), '1, '0, 1'b1);
    send_request(OP_LOCK,    ID_W'(0), '0, '0, 1'b1);
    // Destroy a locked mutex; the create that reuses it must clear the lock.
    send_request(OP_LOCK,    ID_W'(1), '0, '0, 1'b1);
    send_request(OP_DESTROY, ID_W'(1), '0, '0, 1'b1);
    send_request(OP_LOCK,    ID_W'(1), '0, '0, 1'b1);
    send_request(OP_CREATE,  '0, '0, 32'h5A5A_A5A5, 1'b1);
    send_request(OP_LOCK,    ID_W'(1), '1, '0, 1'b1);
    // Destroy twice and a destroy past the end of the table.
    send_request(OP_DESTROY, ID_W'(0), '0, '0, 1'b1);
    send_request(OP_DESTROY, ID_W'(0), '0, '0, 1'b1);
    send_request(OP_DESTROY, '1, '0, '0, 1'b1);
    // The create ignores its id field and reuses the entry just freed.
    send_request(OP_CREATE,  '1, '1, '0, 1'b1);
    drain_results();

    // Random part in phases of 100 requests. The first phase is heavy on
    // creates so the free list runs dry; later phases pick a mix at random.
    for (int phase = 0; phase < 10; phase++) begin
      send_calm = ($urandom_range(3, 0) == 0);
      if (phase == 0) begin
        create_pct  = 80;
        destroy_pct = 5;
      end else begin
        case ($urandom_range(2, 0))
          0:       begin create_pct = 50; destroy_pct = 10; end
          1:       begin create_pct = 15; destroy_pct = 35; end
          default: begin create_pct = 30; destroy_pct = 20; end
        endcase
      end
      for (int n = 0; n < 100; n++) random_request(create_pct, destroy_pct);
      // Now and then let the pipeline empty completely between phases.
      if (phase == 0 || $urandom_range(2, 0) == 0) drain_results();
    end

    // End of run: wait out every result, then keep watching in case the block
    // produces something it was never asked for.
    drain_results();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
